/* rtl/rvex_pkg.sv */
// ----------------------------------------------------------------------------
// RV32I execute unit package
// Opcodes, function codes, default sizes and the execute result type shared
// by the decode/execute logic and the sequencing top level.
// ----------------------------------------------------------------------------
package rvex_pkg;

  // Major opcodes.
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

  // Alternate funct7 (sub, sra, srai).
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_BASE = 7'b0000000;

  // Load and store widths.
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  // Integer operations.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Branch conditions.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Environment call.
  localparam logic [2:0] F3_ECALL = 3'd0;

  // Default data memory size in bytes.
  localparam int MEM_BYTES_DEF = 65536;

  // Result of decoding and executing one instruction against its operands.
  typedef struct packed {
    logic [31:0] npc;
    logic        wr;
    logic [31:0] val;
    logic        halt;
    logic        unk;
    logic        is_load;
    logic        is_store;
    logic [31:0] ea;
  } exec_res_t;

  // Byte offset to word offset, rounding toward zero.
  function automatic logic [31:0] word_off(input logic [31:0] byte_off);
    logic [31:0] adj;
    begin
      adj = byte_off[31] ? byte_off + 32'd3 : byte_off;
      word_off = $signed(adj) >>> 2;
    end
  endfunction

endpackage

/* rtl/rvex_exec.sv */
// ----------------------------------------------------------------------------
// RV32I decode and execute
// Decodes one instruction word and computes its next pc, register result,
// flags and effective memory address from the two source operands.
// ----------------------------------------------------------------------------
module rvex_exec
  import rvex_pkg::*;
(
  input  logic [31:0] instr,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] pc,
  output exec_res_t   res
);

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] immi;
  logic [31:0] imms;
  logic [31:0] immb;
  logic [31:0] immj;
  logic        take;

  assign op = instr[6:0];
  assign f3 = instr[14:12];
  assign f7 = instr[31:25];

  // Immediates, sign-extended to 32 bits.
  assign immi = {{20{instr[31]}}, instr[31:20]};
  assign imms = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign immb = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign immj = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

  // Main decode.
  always_comb begin
    res          = '0;
    res.npc      = pc + 32'd1;
    take         = 1'b0;
    case (op)
      OPC_LOAD: begin
        res.ea = a + immi;
        if (f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}) begin
          res.is_load = 1'b1;
        end else begin
          res.unk = 1'b1;
        end
      end
      OPC_OPIMM: begin
        res.wr = 1'b1;
        case (f3)
          F3_ADD:  res.val = a + immi;
          F3_SLL:  res.val = a << immi[4:0];
          F3_SLT:  res.val = {31'd0, $signed(a) < $signed(immi)};
          F3_SLTU: res.val = {31'd0, a < immi};
          F3_XOR:  res.val = a ^ immi;
          F3_SR: begin
            if (f7 == F7_BASE) begin
              res.val = a >> immi[4:0];
            end else if (f7 == F7_ALT) begin
              res.val = $signed(a) >>> immi[4:0];
            end else begin
              res.unk = 1'b1;
            end
          end
          F3_OR:   res.val = a | immi;
          default: res.val = a & immi;
        endcase
      end
      OPC_STORE: begin
        res.ea = a + imms;
        if (f3 inside {F3_LB, F3_LH, F3_LW}) begin
          res.is_store = 1'b1;
        end else begin
          res.unk = 1'b1;
        end
      end
      OPC_OP: begin
        res.wr = 1'b1;
        case (f3)
          F3_ADD: begin
            if (f7 == F7_BASE) begin
              res.val = a + b;
            end else if (f7 == F7_ALT) begin
              res.val = a - b;
            end else begin
              res.unk = 1'b1;
            end
          end
          F3_SLL:  res.val = a << b[4:0];
          F3_SLT:  res.val = {31'd0, $signed(a) < $signed(b)};
          F3_SLTU: res.val = {31'd0, a < b};
          F3_XOR:  res.val = a ^ b;
          F3_SR: begin
            if (f7 == F7_BASE) begin
              res.val = a >> b[4:0];
            end else if (f7 == F7_ALT) begin
              res.val = $signed(a) >>> b[4:0];
            end else begin
              res.unk = 1'b1;
            end
          end
          F3_OR:   res.val = a | b;
          default: res.val = a & b;
        endcase
      end
      OPC_LUI: begin
        res.wr  = 1'b1;
        res.val = {instr[31:12], 12'd0};
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = $signed(a) < $signed(b);
          F3_BGE:  take = $signed(a) >= $signed(b);
          F3_BLTU: take = a < b;
          F3_BGEU: take = a >= b;
          default: res.unk = 1'b1;
        endcase
        if (take) begin
          res.npc = pc + word_off(immb);
        end
      end
      OPC_JALR: begin
        res.wr  = 1'b1;
        res.val = pc + 32'd1;
        res.npc = a + word_off(immi);
      end
      OPC_JAL: begin
        res.wr  = 1'b1;
        res.val = pc + 32'd1;
        res.npc = pc + word_off(immj);
      end
      OPC_SYSTEM: begin
        if (f3 == F3_ECALL) begin
          res.halt = 1'b1;
        end else begin
          res.unk = 1'b1;
        end
      end
      default: res.unk = 1'b1;
    endcase

    // Halt and unknown instructions leave all state untouched.
    if (res.unk || res.halt) begin
      res.npc = pc;
      res.wr  = 1'b0;
    end
  end

endmodule

/* rtl/rv32i_instruction_execute_unit.sv */
// ----------------------------------------------------------------------------
// RV32I instruction execute unit
// Executes one instruction item at a time against a register file memory,
// a byte-wide data memory and a word-indexed pc, giving one result item each.
//
//   channel | handshake                    | payload
//   --------+------------------------------+-------------------------------
//   input   | in_valid / in_stall          | instr
//   output  | out_valid / out_stall        | next_pc, reg_written,
//           |                              | dest_index, dest_value,
//           |                              | halt, unknown_op
//
// Register and jump instructions complete in the execute state after the
// register file read, so while the output is not held a new item can be
// taken every cycle; the last write is forwarded to the next item's operands.
// Loads and stores (1, 2 or 4 bytes) go through the execute state, the
// multiply states S_MUL1 and S_MUL2 and the correction state S_MOD, which
// reduce the address modulo MEM_BYTES; the single data memory port then moves
// one byte per cycle, loads pass S_LWAIT, and S_FIN forms the result.
// After reset a clearing pass writes zero to all MEM_BYTES bytes, one per
// cycle, and no item is taken until it ends.
// A result waiting in the output register holds up completion, and with it
// the intake of the next item; with nothing in flight an item is still taken.
// ----------------------------------------------------------------------------
module rv32i_instruction_execute_unit
  import rvex_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_pc,
  output logic        reg_written,
  output logic [4:0]  dest_index,
  output logic [31:0] dest_value,
  output logic        halt,
  output logic        unknown_op
);

  localparam int          AW     = $clog2(MEM_BYTES);
  localparam logic [31:0] MB     = 32'(MEM_BYTES);
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / MEM_BYTES);
  localparam logic [AW-1:0] ALAST = AW'(MEM_BYTES - 1);

  // Sequencer states.
  localparam logic [2:0] S_EMPTY = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_MEM   = 3'd5;
  localparam logic [2:0] S_LWAIT = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]    st;
  logic [31:0]   ir;
  logic [31:0]   pc;

  // Register file memory with valid bits standing in for the reset clear.
  logic [31:0]   rf [32];
  logic [31:0]   rf_vld;
  logic [31:0]   rda;
  logic [31:0]   rdb;
  logic          rva;
  logic          rvb;
  logic          fwd_v;
  logic [4:0]    fwd_idx;
  logic [31:0]   fwd_val;
  logic [31:0]   op_a;
  logic [31:0]   op_b;

  // Data memory and its access path.
  logic [7:0]    dmem [MEM_BYTES];
  logic [7:0]    dq;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wd;
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  logic [31:0]   m_ea;
  logic [31:0]   m_b;
  logic          m_ld;
  logic [63:0]   prod;
  logic [31:0]   qm;
  logic [31:0]   r0;
  logic [31:0]   r1;
  logic [31:0]   r2;
  logic [AW-1:0] maddr;
  logic [1:0]    k;
  logic [1:0]    k_last;
  logic          rdv;
  logic [1:0]    rdk;
  logic [31:0]   ld_word;
  logic [31:0]   ld_val;

  exec_res_t     res;
  logic          is_mem;
  logic          fin_go;
  logic          slot_free;
  logic          acc;
  logic [31:0]   f_npc;
  logic          f_wr;
  logic [31:0]   f_val;
  logic          f_halt;
  logic          f_unk;
  logic [4:0]    f_rd;
  logic          f_we;

  // Operands: the register read taken at intake, with the last write forwarded.
  always_comb begin
    op_a = rva ? rda : 32'd0;
    op_b = rvb ? rdb : 32'd0;
    if (fwd_v && fwd_idx == ir[19:15]) begin
      op_a = fwd_val;
    end
    if (fwd_v && fwd_idx == ir[24:20]) begin
      op_b = fwd_val;
    end
  end

  rvex_exec u_exec (
    .instr (ir),
    .a     (op_a),
    .b     (op_b),
    .pc    (pc),
    .res   (res)
  );

  assign is_mem = res.is_load || res.is_store;

  // Handshakes.
  assign slot_free = !out_valid || !out_stall;
  assign fin_go    = slot_free && ((st == S_EXEC && !is_mem) || st == S_FIN);
  assign in_stall  = !(!clr_busy && (st == S_EMPTY || fin_go));
  assign acc       = in_valid && !in_stall;

  // Load data shaped by width and sign.
  always_comb begin
    case (ir[14:12])
      F3_LB:   ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      F3_LH:   ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      F3_LBU:  ld_val = {24'd0, ld_word[7:0]};
      F3_LHU:  ld_val = {16'd0, ld_word[15:0]};
      default: ld_val = ld_word;
    endcase
  end

  // Values of the item that completes this cycle.
  always_comb begin
    if (st == S_FIN) begin
      f_npc  = pc + 32'd1;
      f_wr   = m_ld;
      f_val  = ld_val;
      f_halt = 1'b0;
      f_unk  = 1'b0;
    end else begin
      f_npc  = res.npc;
      f_wr   = res.wr;
      f_val  = res.val;
      f_halt = res.halt;
      f_unk  = res.unk;
    end
    f_rd = ir[11:7];
    f_we = fin_go && f_wr && (f_rd != 5'd0);
  end

  // Address reduction modulo the memory size: estimate is at most one short.
  assign r0 = m_ea - qm;
  assign r1 = (r0 >= MB) ? r0 - MB : r0;
  assign r2 = (r1 >= MB) ? r1 - MB : r1;

  always_comb begin
    case (ir[13:12])
      2'd1:    k_last = 2'd1;
      2'd2:    k_last = 2'd3;
      default: k_last = 2'd0;
    endcase
  end

  // Data memory port: clearing pass or the byte sequencer.
  always_comb begin
    if (clr_busy) begin
      mem_addr = clr_addr;
      mem_we   = 1'b1;
      mem_wd   = 8'd0;
    end else begin
      mem_addr = maddr;
      mem_we   = (st == S_MEM) && !m_ld;
      mem_wd   = m_b[{k, 3'd0} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_addr] <= mem_wd;
    end
    dq <= dmem[mem_addr];
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == ALAST) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Register file: read at intake, written at completion.
  always_ff @(posedge clk) begin
    if (acc) begin
      rda <= rf[instr[19:15]];
      rdb <= rf[instr[24:20]];
    end
    if (f_we) begin
      rf[f_rd] <= f_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld  <= '0;
      rva     <= 1'b0;
      rvb     <= 1'b0;
      fwd_v   <= 1'b0;
      fwd_idx <= '0;
      fwd_val <= '0;
    end else begin
      if (acc) begin
        rva <= rf_vld[instr[19:15]];
        rvb <= rf_vld[instr[24:20]];
      end
      if (f_we) begin
        rf_vld[f_rd] <= 1'b1;
        fwd_v        <= 1'b1;
        fwd_idx      <= f_rd;
        fwd_val      <= f_val;
      end
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= S_EMPTY;
      pc  <= '0;
      rdv <= 1'b0;
    end else begin
      rdv <= (st == S_MEM) && m_ld;
      if (fin_go) begin
        pc <= f_npc;
      end
      case (st)
        S_EXEC: begin
          if (is_mem) begin
            st <= S_MUL1;
          end else if (fin_go) begin
            st <= acc ? S_EXEC : S_EMPTY;
          end
        end
        S_MUL1: st <= S_MUL2;
        S_MUL2: st <= S_MOD;
        S_MOD:  st <= S_MEM;
        S_MEM: begin
          if (k == k_last) begin
            st <= m_ld ? S_LWAIT : S_FIN;
          end
        end
        S_LWAIT: st <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            st <= acc ? S_EXEC : S_EMPTY;
          end
        end
        default: begin
          if (acc) begin
            st <= S_EXEC;
          end
        end
      endcase
    end
  end

  // Payload registers of the item in flight.
  always_ff @(posedge clk) begin
    if (acc) begin
      ir <= instr;
    end
    if (st == S_EXEC && is_mem) begin
      m_ea <= res.ea;
      m_b  <= op_b;
      m_ld <= res.is_load;
    end
    if (st == S_MUL1) begin
      prod <= 64'(m_ea) * 64'(RECIP);
    end
    if (st == S_MUL2) begin
      qm <= prod[63:32] * MB;
    end
    if (st == S_MOD) begin
      maddr <= r2[AW-1:0];
      k     <= 2'd0;
    end
    // A byte address that passes the top of the 32-bit space restarts at zero.
    if (st == S_MEM) begin
      maddr <= (maddr == ALAST || (m_ea + 32'(k)) == 32'hFFFFFFFF) ? '0 :
               maddr + AW'(1);
      k     <= k + 2'd1;
      rdk   <= k;
    end
    if (rdv) begin
      ld_word[{rdk, 3'd0} +: 8] <= dq;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      next_pc     <= f_npc;
      reg_written <= f_we;
      dest_index  <= f_we ? f_rd : 5'd0;
      dest_value  <= f_we ? f_val : 32'd0;
      halt        <= f_halt;
      unknown_op  <= f_unk;
    end
  end

endmodule
